[rtl/core/bsp_pkg.sv]
// ============================================================================
// bsp_pkg
// Shared types and defaults of the bencode stream parser: container stack
// entry, per-cell shift control and the default nesting limit.
// ============================================================================
package bsp_pkg;

    localparam int DEF_MAX_DEPTH = 32;

    // bit 0: level is a dict, bit 1: dict awaits a value
    typedef logic [1:0] t_stk_ent;

    typedef struct packed {
        logic push;
        logic pop;
        logic load;
    } t_stk_ctrl;

endpackage

[rtl/core/bsp_stack_cell.sv]
// ============================================================================
// bsp_stack_cell
// One level of the container stack. Shifts toward the bottom on push, toward
// the top on pop, or loads a new top value.
// ============================================================================
module bsp_stack_cell (
    input  logic               i_clk,
    input  bsp_pkg::t_stk_ctrl i_ctrl,
    input  bsp_pkg::t_stk_ent  i_up,
    input  bsp_pkg::t_stk_ent  i_down,
    output bsp_pkg::t_stk_ent  o_ent
);
    import bsp_pkg::*;

    t_stk_ent r_ent;
    t_stk_ent n_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_ctrl.push || i_ctrl.load) begin
            n_ent = i_up;
        end else if (i_ctrl.pop) begin
            n_ent = i_down;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent = r_ent;

endmodule

[rtl/core/bencode_stream_parser_unit.sv]
// ============================================================================
// bencode_stream_parser_unit
// Streaming bencode syntax checker: one byte request in, one token event out.
// ============================================================================
// Input stream: i_s_tdata carries one byte of the document, i_s_tlast marks
// an end-of-input request whose byte is ignored. Every accepted request
// yields exactly one event on the output stream: event kind, is_key and
// string_last on o_m_tuser, value, string byte and nesting level on
// o_m_tdata, and o_m_tlast when a top-level value completes.
// Throughput is one request per cycle while o_s_tready is high; each event
// is registered in the output buffer. The container stack is a row of cells
// with the top at cell 0, so push and pop shift all cells together and top
// update loads cell 0; the digit accumulate is a 67-bit shift-add per byte.
// A two-entry output buffer lets one more request in while the receiver
// stalls; o_s_tready drops only when both entries are full.
// Reset empties the output buffer and leaves the parser idle at depth 0.
// Errors report event 7 and return the parser to idle at depth 0.
// ============================================================================
module bencode_stream_parser_unit #(
    parameter int MAX_DEPTH = bsp_pkg::DEF_MAX_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_req
    input  logic        i_s_tlast,   // end_of_input
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // [62:0] value, [70:63] data_byte,
                                     // [76:71] nesting_level, [79:77] zero
    output logic [4:0]  o_m_tuser,   // [2:0] event_res, [3] is_key, [4] string_last
    output logic        o_m_tlast    // document_done
);
    import bsp_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_LIMIT = DW'(MAX_DEPTH);

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_EXPECT = 3'd1;
    localparam logic [2:0] MODE_INT    = 3'd2;
    localparam logic [2:0] MODE_SLEN   = 3'd3;
    localparam logic [2:0] MODE_SBODY  = 3'd4;

    localparam logic [2:0] EV_PENDING = 3'd0;
    localparam logic [2:0] EV_INT     = 3'd1;
    localparam logic [2:0] EV_SHDR    = 3'd2;
    localparam logic [2:0] EV_SBYTE   = 3'd3;
    localparam logic [2:0] EV_LIST    = 3'd4;
    localparam logic [2:0] EV_DICT    = 3'd5;
    localparam logic [2:0] EV_CLOSE   = 3'd6;
    localparam logic [2:0] EV_ERROR   = 3'd7;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;

    typedef struct packed {
        logic [2:0]  ev;
        logic [62:0] val;
        logic [7:0]  data;
        logic        key;
        logic        last;
        logic [5:0]  lvl;
        logic        done;
    } t_result;

    // parser state
    logic [2:0]    r_mode,  n_mode;
    logic [DW-1:0] r_depth, n_depth;
    logic [62:0]   r_acc,   n_acc;
    logic [62:0]   r_rem,   n_rem;
    logic          r_key,   n_key;

    // output buffer
    t_result r_out, r_skid, w_res;
    logic    r_out_vld, r_skid_vld;

    // stack chain
    t_stk_ent  w_ent  [MAX_DEPTH];
    t_stk_ent  w_up   [MAX_DEPTH];
    t_stk_ent  w_down [MAX_DEPTH];
    t_stk_ctrl w_cctl [MAX_DEPTH];
    t_stk_ent  w_top, w_below, w_below_mod, s_top_wr;
    logic      s_push, s_pop, s_load;

    logic        w_acc;
    logic [7:0]  w_c;
    logic        w_digit;
    logic [62:0] w_dval;
    logic [66:0] w_prod;
    logic        w_ovf;
    logic [DW+5:0] w_lvl_ext;

    assign w_acc   = i_s_tvalid && o_s_tready;
    assign w_c     = i_s_tdata;
    assign w_digit = (w_c >= CH_0) && (w_c <= CH_9);
    assign w_dval  = 63'(w_c - CH_0) & 63'hF;
    assign w_prod  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {4'b0000, w_dval};
    assign w_ovf   = |w_prod[66:63];

    assign w_top = w_ent[0];
    generate
        if (MAX_DEPTH > 1) begin : g_below
            assign w_below = w_ent[1];
        end else begin : g_no_below
            assign w_below = '0;
        end
    endgenerate
    assign w_below_mod = w_below ^ {w_below[0], 1'b0};

    always_comb begin
        logic          fail, fin, fin_pop;
        logic [DW-1:0] fin_d;
        logic [62:0]   rem1;
        logic          bv, bv_d;

        fail    = 1'b0;
        fin     = 1'b0;
        fin_pop = 1'b0;
        fin_d   = r_depth;
        rem1    = '0;
        bv      = 1'b0;
        bv_d    = 1'b0;

        n_mode  = r_mode;
        n_depth = r_depth;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_key   = r_key;

        s_push   = 1'b0;
        s_pop    = 1'b0;
        s_load   = 1'b0;
        s_top_wr = w_top ^ {w_top[0], 1'b0};

        w_res    = '0;
        w_res.ev = EV_PENDING;

        if (i_s_tlast) begin
            if (!(r_mode == MODE_IDLE && r_depth == '0)) begin
                fail = 1'b1;
            end
        end else if (r_mode == MODE_SBODY) begin
            w_res.ev   = EV_SBYTE;
            w_res.data = w_c;
            w_res.key  = r_key;
            rem1       = (r_rem != '0) ? r_rem - 63'd1 : r_rem;
            n_rem      = rem1;
            if (rem1 == '0) begin
                w_res.last = 1'b1;
                fin        = 1'b1;
            end
        end else if (w_c[7]) begin
            fail = 1'b1;
        end else if (r_mode == MODE_INT) begin
            if (w_digit) begin
                if (w_ovf) fail = 1'b1;
                else       n_acc = w_prod[62:0];
            end else if (w_c == CH_E) begin
                w_res.ev  = EV_INT;
                w_res.val = r_acc;
                n_acc     = '0;
                fin       = 1'b1;
            end else begin
                fail = 1'b1;
            end
        end else if (r_mode == MODE_SLEN) begin
            if (w_digit) begin
                if (w_ovf) fail = 1'b1;
                else       n_acc = w_prod[62:0];
            end else if (w_c == CH_COLON) begin
                w_res.ev  = EV_SHDR;
                w_res.val = r_acc;
                w_res.key = r_key;
                n_rem     = r_acc;
                n_acc     = '0;
                if (r_acc == '0) begin
                    w_res.last = 1'b1;
                    fin        = 1'b1;
                end else begin
                    n_mode = MODE_SBODY;
                end
            end else begin
                fail = 1'b1;
            end
        end else if (r_mode == MODE_EXPECT) begin
            if (r_depth == '0) begin
                bv   = 1'b1;
                bv_d = 1'b0;
            end else if (w_c == CH_E && !w_top[1]) begin
                n_depth  = r_depth - 1'b1;
                s_pop    = 1'b1;
                w_res.ev = EV_CLOSE;
                fin      = 1'b1;
                fin_pop  = 1'b1;
                fin_d    = r_depth - 1'b1;
            end else if (w_top == 2'b01) begin
                if (w_digit) begin
                    n_acc  = w_dval;
                    n_key  = 1'b1;
                    n_mode = MODE_SLEN;
                end else begin
                    fail = 1'b1;
                end
            end else begin
                bv   = 1'b1;
                bv_d = 1'b1;
            end
        end else begin
            n_depth = '0;
            bv      = 1'b1;
            bv_d    = 1'b0;
        end

        if (bv) begin
            if (w_c == CH_I) begin
                n_acc  = '0;
                n_mode = MODE_INT;
            end else if (w_digit) begin
                n_acc  = w_dval;
                n_key  = 1'b0;
                n_mode = MODE_SLEN;
            end else if (w_c == CH_L || w_c == CH_D) begin
                if (bv_d && r_depth >= DEPTH_LIMIT) begin
                    fail = 1'b1;
                end else begin
                    s_push   = 1'b1;
                    s_top_wr = {1'b0, w_c == CH_D};
                    n_depth  = (bv_d ? r_depth : '0) + 1'b1;
                    n_mode   = MODE_EXPECT;
                    w_res.ev = (w_c == CH_D) ? EV_DICT : EV_LIST;
                end
            end else begin
                fail = 1'b1;
            end
        end

        if (fin) begin
            if (fin_d == '0) begin
                n_mode     = MODE_IDLE;
                w_res.done = 1'b1;
            end else begin
                n_mode = MODE_EXPECT;
                if (!fin_pop) s_load = 1'b1;
            end
        end

        if (fail) begin
            n_mode  = MODE_IDLE;
            n_depth = '0;
            n_acc   = '0;
            n_rem   = '0;
            n_key   = 1'b0;
            s_push  = 1'b0;
            s_pop   = 1'b0;
            s_load  = 1'b0;
            w_res   = '0;
            w_res.ev = EV_ERROR;
        end

        w_lvl_ext = {6'd0, n_depth};
        w_res.lvl = w_lvl_ext[5:0];
    end

    generate
        for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
            if (i == 0) begin : g_head
                assign w_up[i]   = s_top_wr;
                assign w_down[i] = w_below_mod;
            end else begin : g_body
                assign w_up[i] = w_ent[i-1];
                if (i == MAX_DEPTH - 1) begin : g_tail
                    assign w_down[i] = '0;
                end else begin : g_mid
                    assign w_down[i] = w_ent[i+1];
                end
            end
            assign w_cctl[i].push = w_acc && s_push;
            assign w_cctl[i].pop  = w_acc && s_pop;
            assign w_cctl[i].load = (i == 0) && w_acc && s_load;

            bsp_stack_cell u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_cctl[i]),
                .i_up   (w_up[i]),
                .i_down (w_down[i]),
                .o_ent  (w_ent[i])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_depth <= '0;
            r_acc   <= '0;
            r_rem   <= '0;
            r_key   <= 1'b0;
        end else if (w_acc) begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_key   <= n_key;
        end
    end

    // two-entry output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_m_tready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= w_acc;
            end
        end else if (w_acc) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_m_tready) begin
            r_out <= r_skid_vld ? r_skid : w_res;
        end else if (w_acc) begin
            r_skid <= w_res;
        end
    end

    assign o_s_tready = !r_skid_vld;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {3'b000, r_out.lvl, r_out.data, r_out.val};
    assign o_m_tuser  = {r_out.last, r_out.key, r_out.ev};
    assign o_m_tlast  = r_out.done;

endmodule
